### sv/ffba_pkg.sv
// Shared types and constants for the first-fit block allocator.
package ffba_pkg;

  // Result status codes
  localparam logic [2:0] STATUS_ALLOCATED = 3'd0;
  localparam logic [2:0] STATUS_NO_MEMORY = 3'd1;
  localparam logic [2:0] STATUS_FREED     = 3'd2;
  localparam logic [2:0] STATUS_NULL      = 3'd3;
  localparam logic [2:0] STATUS_NOT_FOUND = 3'd4;

  // Operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Configuration register indexes
  localparam logic [7:0] CFG_HEAP_BASE = 8'd0;
  localparam logic [7:0] CFG_HEAP_SIZE = 8'd1;

  localparam logic [31:0] RESET_HEAP_BASE = 32'd1048576;
  localparam logic [31:0] RESET_HEAP_SIZE = 32'd1048576;

  // Largest request that still rounds up without overflow
  localparam logic [31:0] MAX_REQUEST = 32'hFFFF_FFFC;

  // Commands broadcast to the cell chain
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_REBUILD,
    CMD_SPLIT,
    CMD_TAKE,
    CMD_MARK_FREE,
    CMD_MERGE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] val_a;
    logic [31:0] val_b;
    logic        tok_start;
    logic        tok_clear;
  } cell_cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_PEEK,
    ST_MERGE_L,
    ST_DONE
  } state_t;

endpackage

### sv/ffba_cell.sv
// One table entry of the allocator: block size, free mark and scan token.
module ffba_cell #(
  parameter int IDX = 0,
  parameter int IW  = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  ffba_pkg::cell_cmd_t cmd,
  input  logic [IW-1:0]      sel,
  input  logic [31:0]        left_size,
  input  logic               left_free,
  input  logic               left_tok,
  input  logic [31:0]        right_size,
  input  logic               right_free,
  output logic [31:0]        size,
  output logic               free,
  output logic               tok
);

  logic [IW:0]   my_idx;
  logic [IW:0]   sel_plus;
  logic          is_sel;
  logic          is_next;
  logic          is_after_next;
  logic          is_after;
  logic [31:0]   size_next;
  logic          free_next;

  assign my_idx        = (IW+1)'(IDX);
  assign sel_plus      = {1'b0, sel} + (IW+1)'(1);
  assign is_sel        = (my_idx == {1'b0, sel});
  assign is_next       = (my_idx == sel_plus);
  assign is_after_next = (my_idx > sel_plus);
  assign is_after      = (my_idx > {1'b0, sel});

  // Entry update for the broadcast command
  always_comb begin
    size_next = size;
    free_next = free;
    unique case (cmd.kind)
      ffba_pkg::CMD_REBUILD: begin
        size_next = (IDX == 0) ? cmd.val_a : 32'd0;
        free_next = (IDX == 0);
      end
      ffba_pkg::CMD_SPLIT: begin
        if (is_sel) begin
          size_next = cmd.val_a;
          free_next = 1'b0;
        end else if (is_next) begin
          size_next = cmd.val_b;
          free_next = 1'b1;
        end else if (is_after_next) begin
          size_next = left_size;
          free_next = left_free;
        end
      end
      ffba_pkg::CMD_TAKE: begin
        if (is_sel) free_next = 1'b0;
      end
      ffba_pkg::CMD_MARK_FREE: begin
        if (is_sel) free_next = 1'b1;
      end
      ffba_pkg::CMD_MERGE: begin
        if (is_sel) begin
          size_next = cmd.val_a;
        end else if (is_after) begin
          size_next = right_size;
          free_next = right_free;
        end
      end
      default: begin
        size_next = size;
        free_next = free;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    size <= size_next;
    if (rst) begin
      free <= 1'b0;
      tok  <= 1'b0;
    end else begin
      free <= free_next;
      // token walks one cell per cycle
      if (cmd.tok_clear) tok <= 1'b0;
      else if (cmd.tok_start) tok <= (IDX == 0);
      else tok <= left_tok;
    end
  end

endmodule

### sv/ffba_ctrl.sv
// Sequencer of the allocator: handshakes, config registers, scan and merge steps.
module ffba_ctrl #(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 12,
  parameter int IW           = 6,
  parameter int CW           = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                op,
  input  logic [31:0]         request_size,
  input  logic [31:0]         block_address,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [31:0]         payload_address,
  output logic [2:0]          status,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic [31:0]         bus_size,
  input  logic                bus_free,
  output ffba_pkg::cell_cmd_t cmd,
  output logic [IW-1:0]       sel
);

  localparam logic [31:0] HDR = 32'(HEADER_BYTES);
  localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);

  ffba_pkg::state_t state, state_next;

  logic [31:0]   heap_base;
  logic [31:0]   heap_size;
  logic          op_q;
  logic [31:0]   need;
  logic [31:0]   addr_q;
  logic [CW-1:0] idx;
  logic [CW-1:0] count;
  logic [31:0]   run;
  logic          prev_free;
  logic [31:0]   prev_size;
  logic [31:0]   cur_size;
  logic [31:0]   res_addr;
  logic [2:0]    res_status;

  logic          cfg_hit;
  logic          in_range;
  logic          next_ok;
  logic          fit;
  logic          split_ok;
  logic          addr_hit;
  logic          merge_r;
  logic          merge_l;
  logic          out_take;
  logic [31:0]   init_size;
  logic [33:0]   split_lim;

  assign cfg_ready = (state == ffba_pkg::ST_IDLE);
  assign in_stall  = (state != ffba_pkg::ST_IDLE) || cfg_valid;
  assign cfg_hit   = (cfg_index == ffba_pkg::CFG_HEAP_BASE) ||
                     (cfg_index == ffba_pkg::CFG_HEAP_SIZE);

  // Scan decisions on the token bus
  assign in_range  = (idx < count);
  assign next_ok   = ((idx + CW'(1)) < count);
  assign fit       = bus_free && (bus_size >= need);
  assign split_lim = {2'b00, need} + {2'b00, HDR} + 34'd4;
  assign split_ok  = ({2'b00, bus_size} > split_lim) && (count < MAXC);
  assign addr_hit  = ((run + HDR) == addr_q);
  assign merge_r   = next_ok && bus_free;
  assign merge_l   = (idx != '0) && prev_free;
  assign out_take  = !out_valid || !out_stall;
  assign init_size = (heap_size > HDR) ? (heap_size - HDR) : 32'd0;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ffba_pkg::ST_INIT: state_next = ffba_pkg::ST_IDLE;
      ffba_pkg::ST_IDLE: begin
        if (cfg_valid) begin
          if (cfg_hit) state_next = ffba_pkg::ST_INIT;
        end else if (in_valid) begin
          if (op == ffba_pkg::OP_ALLOC && request_size > ffba_pkg::MAX_REQUEST)
            state_next = ffba_pkg::ST_DONE;
          else if (op == ffba_pkg::OP_FREE && block_address == 32'd0)
            state_next = ffba_pkg::ST_DONE;
          else
            state_next = ffba_pkg::ST_SCAN;
        end
      end
      ffba_pkg::ST_SCAN: begin
        if (!in_range) state_next = ffba_pkg::ST_DONE;
        else if (op_q == ffba_pkg::OP_ALLOC && fit) state_next = ffba_pkg::ST_DONE;
        else if (op_q == ffba_pkg::OP_FREE && addr_hit) state_next = ffba_pkg::ST_PEEK;
      end
      ffba_pkg::ST_PEEK:    state_next = ffba_pkg::ST_MERGE_L;
      ffba_pkg::ST_MERGE_L: state_next = ffba_pkg::ST_DONE;
      ffba_pkg::ST_DONE:    if (out_take) state_next = ffba_pkg::ST_IDLE;
      default:              state_next = ffba_pkg::ST_IDLE;
    endcase
  end

  // Commands to the cell chain
  always_comb begin
    cmd           = '0;
    cmd.kind      = ffba_pkg::CMD_NONE;
    sel           = idx[IW-1:0];
    unique case (state)
      ffba_pkg::ST_INIT: begin
        cmd.kind      = ffba_pkg::CMD_REBUILD;
        cmd.val_a     = init_size;
        cmd.tok_clear = 1'b1;
      end
      ffba_pkg::ST_IDLE: begin
        cmd.tok_start = (state_next == ffba_pkg::ST_SCAN);
      end
      ffba_pkg::ST_SCAN: begin
        if (!in_range) begin
          cmd.tok_clear = 1'b1;
        end else if (op_q == ffba_pkg::OP_ALLOC && fit) begin
          cmd.tok_clear = 1'b1;
          cmd.kind      = split_ok ? ffba_pkg::CMD_SPLIT : ffba_pkg::CMD_TAKE;
          cmd.val_a     = need;
          cmd.val_b     = bus_size - need - HDR;
        end else if (op_q == ffba_pkg::OP_FREE && addr_hit) begin
          cmd.kind      = ffba_pkg::CMD_MARK_FREE;
        end
      end
      ffba_pkg::ST_PEEK: begin
        cmd.tok_clear = 1'b1;
        if (merge_r) begin
          cmd.kind  = ffba_pkg::CMD_MERGE;
          cmd.val_a = cur_size + bus_size + HDR;
        end
      end
      ffba_pkg::ST_MERGE_L: begin
        sel = idx[IW-1:0] - IW'(1);
        if (merge_l) begin
          cmd.kind  = ffba_pkg::CMD_MERGE;
          cmd.val_a = prev_size + cur_size + HDR;
        end
      end
      ffba_pkg::ST_DONE: cmd.kind = ffba_pkg::CMD_NONE;
      default:           cmd.kind = ffba_pkg::CMD_NONE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ffba_pkg::ST_INIT;
      heap_base <= ffba_pkg::RESET_HEAP_BASE;
      heap_size <= ffba_pkg::RESET_HEAP_SIZE;
      count     <= CW'(1);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ffba_pkg::ST_IDLE && cfg_valid) begin
        if (cfg_index == ffba_pkg::CFG_HEAP_BASE) heap_base <= cfg_data;
        if (cfg_index == ffba_pkg::CFG_HEAP_SIZE) heap_size <= cfg_data;
      end
      if (state == ffba_pkg::ST_INIT) count <= CW'(1);
      if (state == ffba_pkg::ST_SCAN && in_range && op_q == ffba_pkg::OP_ALLOC &&
          fit && split_ok) count <= count + CW'(1);
      if (state == ffba_pkg::ST_PEEK && merge_r) count <= count - CW'(1);
      if (state == ffba_pkg::ST_MERGE_L && merge_l) count <= count - CW'(1);
      // output word register
      if (state == ffba_pkg::ST_DONE && out_take) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // Working registers of the current request
  always_ff @(posedge clk) begin
    if (state == ffba_pkg::ST_IDLE && !cfg_valid && in_valid) begin
      op_q      <= op;
      need      <= (request_size + 32'd3) & ~32'd3;
      addr_q    <= block_address;
      idx       <= '0;
      run       <= heap_base;
      prev_free <= 1'b0;
      res_addr  <= 32'd0;
      if (op == ffba_pkg::OP_ALLOC) res_status <= ffba_pkg::STATUS_NO_MEMORY;
      else if (block_address == 32'd0) res_status <= ffba_pkg::STATUS_NULL;
      else res_status <= ffba_pkg::STATUS_NOT_FOUND;
    end
    if (state == ffba_pkg::ST_SCAN && in_range) begin
      if (op_q == ffba_pkg::OP_ALLOC && fit) begin
        res_addr   <= run + HDR;
        res_status <= ffba_pkg::STATUS_ALLOCATED;
      end else if (op_q == ffba_pkg::OP_FREE && addr_hit) begin
        cur_size   <= bus_size;
        res_status <= ffba_pkg::STATUS_FREED;
      end else begin
        idx       <= idx + CW'(1);
        run       <= run + bus_size + HDR;
        prev_free <= bus_free;
        prev_size <= bus_size;
      end
    end
    if (state == ffba_pkg::ST_PEEK && merge_r) cur_size <= cur_size + bus_size + HDR;
    if (state == ffba_pkg::ST_DONE && out_take) begin
      payload_address <= res_addr;
      status          <= res_status;
    end
  end

endmodule

### sv/first_fit_block_allocator.sv
// Top level of the first-fit block allocator: sequencer and chain of table cells.
//
// Input channel (in_valid/in_stall) takes one request word: op 0 allocates
// request_size bytes, op 1 frees block_address. Output channel
// (out_valid/out_stall) returns one word per request: payload_address and status.
// The table is a row of MAX_BLOCKS cells; a scan token walks one cell per
// cycle, and splits and merges shift the cells by one toward a neighbor.
// Null frees and oversize requests skip the scan and go straight to the
// result. One request is in work at a time; the next is taken once the
// result sits in the output register, even while the receiver stalls it.
// A stalled result holds and blocks completion of the following request only.
// Reset, and a write to heap_base or heap_size over the cfg channel, rebuild
// the table to one free block before requests are taken.
module first_fit_block_allocator #(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [31:0] request_size,
  input  logic [31:0] block_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] payload_address,
  output logic [2:0]  status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);

  ffba_pkg::cell_cmd_t cmd;
  logic [IW-1:0]       sel;
  logic [31:0]         cell_size [MAX_BLOCKS];
  logic                cell_free [MAX_BLOCKS];
  logic                cell_tok  [MAX_BLOCKS];
  logic [31:0]         bus_size;
  logic                bus_free;

  ffba_ctrl #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .HEADER_BYTES(HEADER_BYTES),
    .IW          (IW),
    .CW          (CW)
  ) u_ctrl (
    .clk, .rst,
    .in_valid, .in_stall, .op, .request_size, .block_address,
    .out_valid, .out_stall, .payload_address, .status,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .bus_size, .bus_free, .cmd, .sel
  );

  // Chain of table cells
  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    logic [31:0] l_size, r_size;
    logic        l_free, l_tok, r_free;
    if (g == 0) begin : g_first
      assign l_size = 32'd0;
      assign l_free = 1'b0;
      assign l_tok  = 1'b0;
    end else begin : g_mid
      assign l_size = cell_size[g-1];
      assign l_free = cell_free[g-1];
      assign l_tok  = cell_tok[g-1];
    end
    if (g == MAX_BLOCKS - 1) begin : g_last
      assign r_size = 32'd0;
      assign r_free = 1'b0;
    end else begin : g_inner
      assign r_size = cell_size[g+1];
      assign r_free = cell_free[g+1];
    end
    ffba_cell #(.IDX(g), .IW(IW)) u_cell (
      .clk, .rst, .cmd, .sel,
      .left_size (l_size), .left_free(l_free), .left_tok(l_tok),
      .right_size(r_size), .right_free(r_free),
      .size(cell_size[g]), .free(cell_free[g]), .tok(cell_tok[g])
    );
  end

  // Token bus: the cell holding the token drives its entry
  always_comb begin
    bus_size = 32'd0;
    bus_free = 1'b0;
    for (int k = 0; k < MAX_BLOCKS; k++) begin
      bus_size = bus_size | (cell_size[k] & {32{cell_tok[k]}});
      bus_free = bus_free | (cell_free[k] & cell_tok[k]);
    end
  end

endmodule

### sv/ffba_checker.sv
// Port-level checks for the first-fit block allocator, bound to the top level.
module ffba_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] payload_address,
  input logic [2:0]  status
);

  // Status codes stay in the defined range
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status <= ffba_pkg::STATUS_NOT_FOUND))
    else $error("status code out of range");

  // Only a successful allocate carries an address
  a_zero_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ffba_pkg::STATUS_ALLOCATED |-> payload_address == 32'd0)
    else $error("nonzero address on a non-allocate result");

  // No result word right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result word right after reset");

  // A stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(payload_address) && $stable(status))
    else $error("stalled result word changed");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
  .clk, .rst, .out_valid, .out_stall, .payload_address, .status
);
